// ===== rtl/dbsa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Divided bitmap slot allocator package
// Shared field widths, command and status codes, parameter defaults and the
// control structs between the sequencer and the free count file.
// ----------------------------------------------------------------------------
package dbsa_pkg;

    localparam int DEF_DIVISIONS      = 8;
    localparam int DEF_DIVISION_SLOTS = 1024;
    localparam int DEF_BATCH          = 16;

    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;
    localparam int SLOT_W    = 14;
    localparam int CMD_W     = 2;
    localparam int STAT_W    = 2;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BATCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

    localparam logic [STAT_W-1:0] ST_ALLOC = 2'd0;
    localparam logic [STAT_W-1:0] ST_NONE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FREED = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic inc;
        logic dec;
    } t_cnt_cmd;

    typedef struct packed {
        logic zero;
        logic full;
    } t_cnt_stat;

endpackage
`default_nettype wire

// ===== rtl/dbsa_bitmap_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot bitmap memory
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module dbsa_bitmap_ram #(
    parameter int DEPTH = 129,
    parameter int AW    = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_wr_en,
    input  wire logic [AW-1:0]                  i_wr_addr,
    input  wire logic [dbsa_pkg::WORD_BITS-1:0] i_wr_data,
    input  wire logic                           i_rd_en,
    input  wire logic [AW-1:0]                  i_rd_addr,
    output logic      [dbsa_pkg::WORD_BITS-1:0] o_rd_data
);
    import dbsa_pkg::*;

    logic [WORD_BITS-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/dbsa_bit_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lowest clear bit scan
// Six-step halving search for the lowest clear bit of a bitmap word.
// ----------------------------------------------------------------------------
module dbsa_bit_scan (
    input  wire logic [dbsa_pkg::WORD_BITS-1:0] i_word,
    output logic                                o_full,
    output logic      [dbsa_pkg::BIT_W-1:0]     o_bit
);
    import dbsa_pkg::*;

    always_comb begin
        logic [WORD_BITS-1:0] w;
        logic [WORD_BITS-1:0] lowmask;
        logic [BIT_W-1:0]     b;
        int                   half;
        w = i_word;
        b = '0;
        for (int k = BIT_W - 1; k >= 0; k--) begin
            half    = 1 << k;
            lowmask = (64'(1) << half) - 64'(1);
            if ((w & lowmask) == lowmask) begin
                b = b | BIT_W'(half);
                w = w >> half;
            end
        end
        o_bit  = b;
        o_full = &i_word;
    end

endmodule
`default_nettype wire

// ===== rtl/dbsa_count_file.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Division free count file
// Per-division free counts with saturating increment and floored decrement.
// ----------------------------------------------------------------------------
module dbsa_count_file #(
    parameter int DIVISIONS      = 8,
    parameter int DIVISION_SLOTS = 1024,
    parameter int DW             = 3,
    parameter int CW             = 11
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [DW-1:0]       i_idx,
    input  wire dbsa_pkg::t_cnt_cmd  i_cmd,
    output logic      [CW-1:0]       o_count,
    output dbsa_pkg::t_cnt_stat      o_stat
);
    import dbsa_pkg::*;

    localparam logic [CW-1:0] CAP_STD  = CW'(DIVISION_SLOTS);
    localparam logic [CW-1:0] CAP_LAST = CW'(DIVISION_SLOTS + WORD_BITS);
    localparam logic [DW-1:0] LAST_DIV = DW'(DIVISIONS - 1);

    logic [CW-1:0] r_cnt [DIVISIONS];
    logic [CW-1:0] cap;

    assign o_count     = r_cnt[i_idx];
    assign cap         = (i_idx == LAST_DIV) ? CAP_LAST : CAP_STD;
    assign o_stat.zero = (o_count == '0);
    assign o_stat.full = (o_count >= cap);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < DIVISIONS; d++) begin
                r_cnt[d] <= (d == DIVISIONS - 1) ? CAP_LAST : CAP_STD;
            end
        end else if (i_cmd.inc && !o_stat.full) begin
            r_cnt[i_idx] <= o_count + CW'(1);
        end else if (i_cmd.dec && !o_stat.zero) begin
            r_cnt[i_idx] <= o_count - CW'(1);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/divided_bitmap_slot_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Divided bitmap slot allocator
// Sequencer, slot bitmap, count file and output register of the allocator.
//
//   channel  direction  handshake                      payload
//   in       sink       i_in_valid / o_in_ready        i_cmd, i_slot_index
//   out      source     o_out_valid / i_out_ready      o_status, o_granted_slot,
//                                                      o_wake_writer, o_last
//
// Free: the division is found by repeated subtraction, then the bitmap word is
// read and written back with the slot bit cleared. Allocate: the division with
// the most free slots is picked (the later one on a tie), then its words are
// read through the single bitmap read port, full words skipped and one slot
// granted per clear bit found. After reset a clearing pass zeroes the
// DIVISIONS*DIVISION_SLOTS/64+1 words (129 at default), taking no transaction.
// A stalled output holds the sequencer only when a further result is due.
// ----------------------------------------------------------------------------
module divided_bitmap_slot_allocator #(
    parameter int DIVISIONS      = dbsa_pkg::DEF_DIVISIONS,
    parameter int DIVISION_SLOTS = dbsa_pkg::DEF_DIVISION_SLOTS,
    parameter int BATCH          = dbsa_pkg::DEF_BATCH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [dbsa_pkg::CMD_W-1:0]    i_cmd,
    input  wire logic [dbsa_pkg::SLOT_W-1:0]   i_slot_index,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [dbsa_pkg::STAT_W-1:0]   o_status,
    output logic      [dbsa_pkg::SLOT_W-1:0]   o_granted_slot,
    output logic                               o_wake_writer,
    output logic                               o_last
);
    import dbsa_pkg::*;

    localparam int WPD         = DIVISION_SLOTS / WORD_BITS;
    localparam int TOTAL_WORDS = DIVISIONS * WPD + 1;
    localparam int TOTAL_SLOTS = TOTAL_WORDS * WORD_BITS;
    localparam int MW          = $clog2(TOTAL_WORDS);
    localparam int AW          = $clog2(TOTAL_WORDS + 1);
    localparam int DW          = (DIVISIONS > 1) ? $clog2(DIVISIONS) : 1;
    localparam int CW          = $clog2(DIVISION_SLOTS + WORD_BITS + 1);
    localparam int NW          = $clog2(BATCH + 1);
    localparam logic [DW-1:0] LAST_DIV = DW'(DIVISIONS - 1);

    typedef enum logic [10:0] {
        S_CLEAR = 11'b000_0000_0001,
        S_IDLE  = 11'b000_0000_0010,
        S_FDIV  = 11'b000_0000_0100,
        S_FRD   = 11'b000_0000_1000,
        S_FWR   = 11'b000_0001_0000,
        S_ERR   = 11'b000_0010_0000,
        S_PICK  = 11'b000_0100_0000,
        S_ACHK  = 11'b000_1000_0000,
        S_ARD   = 11'b001_0000_0000,
        S_AWR   = 11'b010_0000_0000,
        S_AEND  = 11'b100_0000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_addr, n_addr;
    logic [AW-1:0]     r_end, n_end;
    logic [AW-1:0]     r_rem, n_rem;
    logic [DW-1:0]     r_div, n_div;
    logic [DW-1:0]     r_bidx, n_bidx;
    logic [CW-1:0]     r_best, n_best;
    logic [NW-1:0]     r_limit, n_limit;
    logic [NW-1:0]     r_n, n_n;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic [SLOT_W-1:0] r_pend_slot, n_pend_slot;
    logic              r_have_pend, n_have_pend;

    logic              r_ovalid;
    logic [STAT_W-1:0] r_ostatus;
    logic [SLOT_W-1:0] r_oslot;
    logic              r_owake;
    logic              r_olast;

    logic              push;
    logic [STAT_W-1:0] push_status;
    logic [SLOT_W-1:0] push_slot;
    logic              push_wake;
    logic              push_last;
    logic              space;

    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [WORD_BITS-1:0] rd_data;
    logic                 scan_full;
    logic [BIT_W-1:0]     scan_bit;
    logic [AW-1:0]        div_start;

    t_cnt_cmd          cnt_cmd;
    t_cnt_stat         cnt_stat;
    logic [CW-1:0]     cnt_value;

    dbsa_bitmap_ram #(
        .DEPTH (TOTAL_WORDS),
        .AW    (MW)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_addr[MW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr[MW-1:0]),
        .o_rd_data (rd_data)
    );

    dbsa_bit_scan u_scan (
        .i_word (rd_data),
        .o_full (scan_full),
        .o_bit  (scan_bit)
    );

    dbsa_count_file #(
        .DIVISIONS      (DIVISIONS),
        .DIVISION_SLOTS (DIVISION_SLOTS),
        .DW             (DW),
        .CW             (CW)
    ) u_counts (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_idx   (r_div),
        .i_cmd   (cnt_cmd),
        .o_count (cnt_value),
        .o_stat  (cnt_stat)
    );

    assign space      = !r_ovalid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign div_start  = AW'(32'(r_bidx) * WPD);

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_end       = r_end;
        n_rem       = r_rem;
        n_div       = r_div;
        n_bidx      = r_bidx;
        n_best      = r_best;
        n_limit     = r_limit;
        n_n         = r_n;
        n_bit       = r_bit;
        n_pend_slot = r_pend_slot;
        n_have_pend = r_have_pend;
        push        = 1'b0;
        push_status = ST_NONE;
        push_slot   = '0;
        push_wake   = 1'b0;
        push_last   = 1'b1;
        wr_en       = 1'b0;
        wr_data     = '0;
        rd_en       = 1'b0;
        cnt_cmd     = '0;

        case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                if (r_addr == AW'(TOTAL_WORDS - 1)) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_cmd)
                        CMD_ALLOC, CMD_BATCH: begin
                            n_limit = (i_cmd == CMD_BATCH) ? NW'(BATCH) : NW'(1);
                            n_div   = '0;
                            n_best  = '0;
                            n_bidx  = '0;
                            n_state = S_PICK;
                        end
                        CMD_FREE: begin
                            if (32'(i_slot_index) >= TOTAL_SLOTS) begin
                                n_state = S_ERR;
                            end else begin
                                n_rem   = AW'(i_slot_index >> BIT_W);
                                n_addr  = AW'(i_slot_index >> BIT_W);
                                n_bit   = i_slot_index[BIT_W-1:0];
                                n_div   = '0;
                                n_state = S_FDIV;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FDIV: begin
                if (32'(r_rem) >= WPD && r_div != LAST_DIV) begin
                    n_rem = r_rem - AW'(WPD);
                    n_div = r_div + DW'(1);
                end else begin
                    n_state = S_FRD;
                end
            end
            S_FRD: begin
                rd_en   = 1'b1;
                n_state = S_FWR;
            end
            S_FWR: begin
                if (space) begin
                    wr_en       = 1'b1;
                    wr_data     = rd_data & ~(64'(1) << r_bit);
                    cnt_cmd.inc = 1'b1;
                    push        = 1'b1;
                    push_status = ST_FREED;
                    push_wake   = cnt_stat.zero;
                    n_state     = S_IDLE;
                end
            end
            S_ERR: begin
                if (space) begin
                    push        = 1'b1;
                    push_status = ST_RANGE;
                    n_state     = S_IDLE;
                end
            end
            S_PICK: begin
                if (r_best <= cnt_value) begin
                    n_best = cnt_value;
                    n_bidx = r_div;
                end
                if (r_div == LAST_DIV) begin
                    n_state = S_ACHK;
                end else begin
                    n_div = r_div + DW'(1);
                end
            end
            S_ACHK: begin
                n_div       = r_bidx;
                n_have_pend = 1'b0;
                n_n         = '0;
                if (r_best == '0) begin
                    n_state = S_AEND;
                end else begin
                    n_addr  = div_start;
                    n_end   = div_start + AW'(WPD) + ((r_bidx == LAST_DIV) ? AW'(1) : AW'(0));
                    n_state = S_ARD;
                end
            end
            S_ARD: begin
                if (r_addr == r_end || r_n == r_limit) begin
                    n_state = S_AEND;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_AWR;
                end
            end
            S_AWR: begin
                if (scan_full) begin
                    n_addr  = r_addr + AW'(1);
                    n_state = S_ARD;
                end else if (!r_have_pend || space) begin
                    if (r_have_pend) begin
                        push        = 1'b1;
                        push_status = ST_ALLOC;
                        push_slot   = r_pend_slot;
                        push_last   = 1'b0;
                    end
                    wr_en       = 1'b1;
                    wr_data     = rd_data | (64'(1) << scan_bit);
                    cnt_cmd.dec = 1'b1;
                    n_pend_slot = SLOT_W'({r_addr[MW-1:0], scan_bit});
                    n_have_pend = 1'b1;
                    n_n         = r_n + NW'(1);
                    n_state     = S_ARD;
                end
            end
            S_AEND: begin
                if (space) begin
                    push = 1'b1;
                    if (r_have_pend) begin
                        push_status = ST_ALLOC;
                        push_slot   = r_pend_slot;
                    end
                    n_have_pend = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_have_pend <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_have_pend <= n_have_pend;
            if (push) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_end       <= n_end;
        r_rem       <= n_rem;
        r_div       <= n_div;
        r_bidx      <= n_bidx;
        r_best      <= n_best;
        r_limit     <= n_limit;
        r_n         <= n_n;
        r_bit       <= n_bit;
        r_pend_slot <= n_pend_slot;
        if (push) begin
            r_ostatus <= push_status;
            r_oslot   <= push_slot;
            r_owake   <= push_wake;
            r_olast   <= push_last;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_status       = r_ostatus;
    assign o_granted_slot = r_oslot;
    assign o_wake_writer  = r_owake;
    assign o_last         = r_olast;

endmodule
`default_nettype wire
